FILE: src/abbsm_pkg.sv
// ----------------------------------------------------------------------------
// abbsm_pkg
// Types and constants shared by the A/B boot slot manager modules.
// ----------------------------------------------------------------------------
package abbsm_pkg;

   typedef enum logic [2:0] {
      PH_STARTUP = 3'd0,
      PH_CHECK   = 3'd1,
      PH_IDLE    = 3'd2,
      PH_SD      = 3'd3,
      PH_UART    = 3'd4,
      PH_WAITKEY = 3'd5,
      PH_ERROR   = 3'd6,
      PH_JUMPED  = 3'd7
   } abbsm_phase_type;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_SD_REQ    = 3'd1,
      OP_UART_REQ  = 3'd2,
      OP_DL_DONE   = 3'd3,
      OP_JUMP_FAIL = 3'd4
   } abbsm_op_type;

   // slot states
   localparam logic [1:0] ST_EMPTY     = 2'd0;
   localparam logic [1:0] ST_NEW       = 2'd1;
   localparam logic [1:0] ST_CONFIRMED = 2'd2;
   localparam logic [1:0] ST_UNUSED    = 2'd3;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [2:0] CSR_ATTEMPT_LIMIT  = 3'd0;
   localparam logic [2:0] CSR_STARTUP_TICKS  = 3'd1;
   localparam logic [2:0] CSR_WAIT_TICKS     = 3'd2;
   localparam logic [2:0] CSR_STORED_ACTIVE  = 3'd3;
   localparam logic [2:0] CSR_STORED_STATE_A = 3'd4;
   localparam logic [2:0] CSR_STORED_STATE_B = 3'd5;
   localparam logic [2:0] CSR_STORED_ATTEMPTS = 3'd6;
   localparam int unsigned CSR_DATA_WIDTH = 16;

   localparam logic [7:0]  ATTEMPT_LIMIT_RESET = 8'd3;
   localparam logic [15:0] STARTUP_TICKS_RESET = 16'd200;
   localparam logic [15:0] WAIT_TICKS_RESET    = 16'd3000;
   localparam logic [7:0]  ATTEMPTS_MAX        = 8'hFF;

   typedef struct packed {
      logic [2:0] operation;
      logic       slot_a_ok;
      logic       slot_b_ok;
      logic       download_ok;
   } abbsm_req_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       boot_slot;
      logic       active_slot_out;
      logic [1:0] state_a_out;
      logic [1:0] state_b_out;
      logic [7:0] attempts_out;
      logic       image_valid;
      logic       jump_now;
      logic       save_params;
      logic       start_download;
      logic       download_source;
      logic       download_slot;
   } abbsm_rsp_type;

   typedef struct packed {
      logic [7:0]  attempt_limit;
      logic [15:0] startup_ticks;
      logic [15:0] wait_ticks;
   } abbsm_cfg_type;

   // writes of the stored boot parameters, loaded into state during startup
   typedef struct packed {
      logic       active_en;
      logic       active;
      logic       state_a_en;
      logic [1:0] state_a;
      logic       state_b_en;
      logic [1:0] state_b;
      logic       attempts_en;
      logic [7:0] attempts;
   } abbsm_load_type;

   typedef struct packed {
      abbsm_phase_type phase;
      logic            sd_pending;
      logic            uart_pending;
      logic            valid_flag;
      logic            chosen;
      logic            active;
      logic [1:0]      state_a;
      logic [1:0]      state_b;
      logic [7:0]      attempts;
      logic            dl_busy;
   } abbsm_state_type;

   localparam abbsm_state_type STATE_RESET = '{
      phase:        PH_STARTUP,
      sd_pending:   1'b0,
      uart_pending: 1'b0,
      valid_flag:   1'b0,
      chosen:       1'b0,
      active:       1'b0,
      state_a:      ST_EMPTY,
      state_b:      ST_EMPTY,
      attempts:     8'd0,
      dl_busy:      1'b0
   };

endpackage

FILE: src/abbsm_csr.sv
// ----------------------------------------------------------------------------
// abbsm_csr
// Configuration registers and decode of stored boot parameter writes.
// ----------------------------------------------------------------------------
module abbsm_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [abbsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [abbsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output abbsm_pkg::abbsm_cfg_type              cfg,
   output abbsm_pkg::abbsm_load_type             load
);

   abbsm_pkg::abbsm_cfg_type cfg_ff, cfg_in;
   logic                     wr;
   logic [1:0]               st_norm;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid;
   // code three reads as empty
   assign st_norm   = (csr_data[1:0] == abbsm_pkg::ST_UNUSED) ? abbsm_pkg::ST_EMPTY
                                                              : csr_data[1:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (csr_index)
            abbsm_pkg::CSR_ATTEMPT_LIMIT: cfg_in.attempt_limit = csr_data[7:0];
            abbsm_pkg::CSR_STARTUP_TICKS: cfg_in.startup_ticks = csr_data[15:0];
            abbsm_pkg::CSR_WAIT_TICKS:    cfg_in.wait_ticks    = csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attempt_limit <= abbsm_pkg::ATTEMPT_LIMIT_RESET;
         cfg_ff.startup_ticks <= abbsm_pkg::STARTUP_TICKS_RESET;
         cfg_ff.wait_ticks    <= abbsm_pkg::WAIT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   always_comb begin
      load             = '0;
      load.active      = csr_data[0];
      load.state_a     = st_norm;
      load.state_b     = st_norm;
      load.attempts    = csr_data[7:0];
      load.active_en   = wr && (csr_index == abbsm_pkg::CSR_STORED_ACTIVE);
      load.state_a_en  = wr && (csr_index == abbsm_pkg::CSR_STORED_STATE_A);
      load.state_b_en  = wr && (csr_index == abbsm_pkg::CSR_STORED_STATE_B);
      load.attempts_en = wr && (csr_index == abbsm_pkg::CSR_STORED_ATTEMPTS);
   end

endmodule

FILE: src/abbsm_in_stage.sv
// ----------------------------------------------------------------------------
// abbsm_in_stage
// Input register for request transactions.
// ----------------------------------------------------------------------------
module abbsm_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  abbsm_pkg::abbsm_req_type req_payload,
   input  logic                     take,
   output logic                     item_valid,
   output abbsm_pkg::abbsm_req_type item
);

   logic                     valid_ff, valid_in;
   abbsm_pkg::abbsm_req_type item_ff, item_in;
   logic                     load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load || (valid_ff && !take);
   assign item_in   = load ? req_payload : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: src/abbsm_core.sv
// ----------------------------------------------------------------------------
// abbsm_core
// Boot phase machine: state registers and single-pass next-state logic.
// ----------------------------------------------------------------------------
module abbsm_core #(
   parameter int unsigned TICK_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  abbsm_pkg::abbsm_req_type  item,
   input  abbsm_pkg::abbsm_cfg_type  cfg,
   input  abbsm_pkg::abbsm_load_type load,
   output abbsm_pkg::abbsm_rsp_type  rsp
);

   abbsm_pkg::abbsm_state_type st_ff, st_in, nx;
   logic [TICK_WIDTH-1:0]      el_ff, el_in, el_nx;
   logic                       p_save, p_jump, p_start;
   logic                       acceptor, decided, prev, other, ok_a, ok_b;
   logic [1:0]                 ps;

   function automatic logic [1:0] state_of(abbsm_pkg::abbsm_state_type s, logic slot);
      return slot ? s.state_b : s.state_a;
   endfunction

   function automatic abbsm_pkg::abbsm_state_type set_state(
      abbsm_pkg::abbsm_state_type s, logic slot, logic [1:0] v);
      abbsm_pkg::abbsm_state_type r;
      r = s;
      if (slot) r.state_b = v;
      else      r.state_a = v;
      return r;
   endfunction

   function automatic abbsm_pkg::abbsm_state_type jump_to(
      abbsm_pkg::abbsm_state_type s, logic slot);
      abbsm_pkg::abbsm_state_type r;
      r        = s;
      r.phase  = abbsm_pkg::PH_JUMPED;
      r.active = slot;
      if (state_of(s, slot) != abbsm_pkg::ST_CONFIRMED) begin
         r = set_state(r, slot, abbsm_pkg::ST_NEW);
         if (r.attempts != abbsm_pkg::ATTEMPTS_MAX) r.attempts = r.attempts + 8'd1;
      end else begin
         r.attempts = 8'd0;
      end
      return r;
   endfunction

   function automatic logic ok_of(logic a, logic b, logic slot);
      return slot ? b : a;
   endfunction

   always_comb begin
      nx       = st_ff;
      el_nx    = el_ff;
      p_save   = 1'b0;
      p_jump   = 1'b0;
      p_start  = 1'b0;
      decided  = 1'b0;
      ok_a     = item.slot_a_ok;
      ok_b     = item.slot_b_ok;
      prev     = st_ff.active;
      other    = !st_ff.active;
      ps       = state_of(st_ff, st_ff.active);
      acceptor = (st_ff.phase == abbsm_pkg::PH_IDLE) ||
                 (st_ff.phase == abbsm_pkg::PH_WAITKEY) ||
                 (st_ff.phase == abbsm_pkg::PH_ERROR);

      case (item.operation)
         abbsm_pkg::OP_TICK: begin
            if (el_nx != {TICK_WIDTH{1'b1}}) el_nx = el_nx + 1'b1;
            unique case (st_ff.phase)
               abbsm_pkg::PH_STARTUP: begin
                  if (el_nx > TICK_WIDTH'(cfg.startup_ticks)) nx.phase = abbsm_pkg::PH_CHECK;
               end
               abbsm_pkg::PH_CHECK: begin
                  if (ps == abbsm_pkg::ST_NEW) begin
                     decided = 1'b1;
                     if (st_ff.attempts >= cfg.attempt_limit) begin
                        nx          = set_state(nx, prev, abbsm_pkg::ST_EMPTY);
                        nx.chosen   = other;
                        nx.active   = other;
                        nx.attempts = 8'd0;
                        p_save      = 1'b1;
                     end else begin
                        nx.chosen = prev;
                     end
                  end else if (ps == abbsm_pkg::ST_CONFIRMED) begin
                     if (ok_of(ok_a, ok_b, prev)) begin
                        nx.chosen = prev;
                        decided   = 1'b1;
                     end else if (ok_of(ok_a, ok_b, other) &&
                                  state_of(st_ff, other) == abbsm_pkg::ST_CONFIRMED) begin
                        nx.chosen = other;
                        nx.active = other;
                        decided   = 1'b1;
                     end
                     if (decided) begin
                        nx.attempts = 8'd0;
                        p_save      = 1'b1;
                     end
                  end else begin
                     // scan both slots, prefer a confirmed B only over an unconfirmed A
                     decided = ok_a || ok_b;
                     if (ok_a && ok_b) begin
                        nx.chosen = (st_ff.state_b == abbsm_pkg::ST_CONFIRMED) &&
                                    (st_ff.state_a != abbsm_pkg::ST_CONFIRMED);
                     end else begin
                        nx.chosen = ok_b;
                     end
                     if (decided) begin
                        nx.active   = nx.chosen;
                        nx.attempts = 8'd0;
                        p_save      = 1'b1;
                     end else begin
                        nx.chosen = st_ff.chosen;
                     end
                  end
                  if (decided && ok_of(ok_a, ok_b, nx.chosen)) nx.valid_flag = 1'b1;
                  nx.phase = abbsm_pkg::PH_IDLE;
                  el_nx    = '0;
               end
               abbsm_pkg::PH_IDLE: begin
                  if (st_ff.sd_pending) begin
                     nx.sd_pending = 1'b0;
                     nx.phase      = abbsm_pkg::PH_SD;
                  end else if (st_ff.uart_pending) begin
                     nx.uart_pending = 1'b0;
                     nx.phase        = abbsm_pkg::PH_UART;
                  end else if (el_nx > TICK_WIDTH'(cfg.wait_ticks)) begin
                     if (st_ff.valid_flag && ok_of(ok_a, ok_b, st_ff.chosen)) begin
                        nx     = jump_to(nx, st_ff.chosen);
                        p_save = 1'b1;
                        p_jump = 1'b1;
                     end else begin
                        nx.phase = abbsm_pkg::PH_WAITKEY;
                     end
                  end
               end
               abbsm_pkg::PH_SD, abbsm_pkg::PH_UART: begin
                  if (!st_ff.dl_busy) begin
                     nx.dl_busy = 1'b1;
                     p_start    = 1'b1;
                  end
               end
               abbsm_pkg::PH_WAITKEY, abbsm_pkg::PH_ERROR: begin
                  if (st_ff.sd_pending) begin
                     nx.sd_pending = 1'b0;
                     nx.phase      = abbsm_pkg::PH_SD;
                     el_nx         = '0;
                  end else if (st_ff.uart_pending) begin
                     nx.uart_pending = 1'b0;
                     nx.phase        = abbsm_pkg::PH_UART;
                     el_nx           = '0;
                  end
               end
               abbsm_pkg::PH_JUMPED: ;
            endcase
         end
         abbsm_pkg::OP_SD_REQ: begin
            if (acceptor) nx.sd_pending = 1'b1;
         end
         abbsm_pkg::OP_UART_REQ: begin
            if (acceptor) nx.uart_pending = 1'b1;
         end
         abbsm_pkg::OP_DL_DONE: begin
            if ((st_ff.phase == abbsm_pkg::PH_SD || st_ff.phase == abbsm_pkg::PH_UART) &&
                st_ff.dl_busy) begin
               nx.dl_busy = 1'b0;
               // target is always the inactive slot
               if (item.download_ok && ok_of(ok_a, ok_b, other)) begin
                  nx            = set_state(nx, other, abbsm_pkg::ST_NEW);
                  nx.active     = other;
                  nx.attempts   = 8'd0;
                  nx.chosen     = other;
                  nx.valid_flag = 1'b1;
                  nx            = jump_to(nx, other);
                  p_save        = 1'b1;
                  p_jump        = 1'b1;
               end else begin
                  nx.phase = abbsm_pkg::PH_WAITKEY;
               end
            end
         end
         abbsm_pkg::OP_JUMP_FAIL: begin
            if (st_ff.phase == abbsm_pkg::PH_JUMPED) nx.phase = abbsm_pkg::PH_ERROR;
         end
         default: ;
      endcase
   end

   // stored parameter writes reach the live state only during startup
   always_comb begin
      st_in = st_ff;
      el_in = el_ff;
      if (advance) begin
         st_in = nx;
         el_in = el_nx;
      end else if (st_ff.phase == abbsm_pkg::PH_STARTUP) begin
         if (load.active_en)   st_in.active   = load.active;
         if (load.state_a_en)  st_in.state_a  = load.state_a;
         if (load.state_b_en)  st_in.state_b  = load.state_b;
         if (load.attempts_en) st_in.attempts = load.attempts;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= abbsm_pkg::STATE_RESET;
         el_ff <= '0;
      end else begin
         st_ff <= st_in;
         el_ff <= el_in;
      end
   end

   always_comb begin
      rsp.phase           = nx.phase;
      rsp.boot_slot       = nx.chosen;
      rsp.active_slot_out = nx.active;
      rsp.state_a_out     = nx.state_a;
      rsp.state_b_out     = nx.state_b;
      rsp.attempts_out    = nx.attempts;
      rsp.image_valid     = nx.valid_flag;
      rsp.jump_now        = p_jump;
      rsp.save_params     = p_save;
      rsp.start_download  = p_start;
      rsp.download_source = (nx.phase == abbsm_pkg::PH_UART);
      rsp.download_slot   = !nx.active;
   end

endmodule

FILE: src/abbsm_rsp_stage.sv
// ----------------------------------------------------------------------------
// abbsm_rsp_stage
// Result register for response transactions.
// ----------------------------------------------------------------------------
module abbsm_rsp_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  abbsm_pkg::abbsm_rsp_type rsp_next,
   output logic                     free,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output abbsm_pkg::abbsm_rsp_type rsp_payload
);

   logic                     valid_ff, valid_in;
   abbsm_pkg::abbsm_rsp_type data_ff, data_in;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = advance || (valid_ff && !rsp_ready);
   assign data_in  = advance ? rsp_next : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

FILE: src/ab_boot_slot_manager_top.sv
// ----------------------------------------------------------------------------
// ab_boot_slot_manager_top
// A/B boot slot manager: boot phase machine with retry and rollback.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                              | Direction | Moves
//  --------+------------------------------------+-----------+-----------------------
//  req     | req_valid req_ready req_payload    | in        | tick or event
//  rsp     | rsp_valid rsp_ready rsp_payload    | out       | phase, slots, pulses
//  csr     | csr_valid csr_ready csr_index/data | in        | register write
//
//  Flow: a transaction is held in the input register; the phase machine then
//  updates its state and the result register together, and one transaction
//  is taken every cycle unless rsp_ready low stalls the result register.
//  Reset: synchronous; settings return to 3 / 200 / 3000 and the state to
//  startup with slot A, both slots empty and zero attempts.
//  Stalls: rsp_ready low holds the result register; the input register still
//  takes one more transaction, after which req_ready drops.
//  csr_ready is always high; stored parameter writes load the live state
//  only while the phase is startup.
//
module ab_boot_slot_manager_top #(
   parameter int unsigned TICK_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  abbsm_pkg::abbsm_req_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output abbsm_pkg::abbsm_rsp_type              rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [abbsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [abbsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   abbsm_pkg::abbsm_cfg_type  cfg;
   abbsm_pkg::abbsm_load_type load;
   abbsm_pkg::abbsm_req_type  item;
   abbsm_pkg::abbsm_rsp_type  rsp_next;
   logic                      item_valid;
   logic                      out_free;
   logic                      advance;

   // one transaction moves from the input register into the result register
   assign advance = item_valid && out_free;

   abbsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .load      (load)
   );

   abbsm_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .take        (out_free),
      .item_valid  (item_valid),
      .item        (item)
   );

   abbsm_core #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .cfg     (cfg),
      .load    (load),
      .rsp     (rsp_next)
   );

   abbsm_rsp_stage u_rsp (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rsp_next    (rsp_next),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: src/abbsm_checker.sv
// ----------------------------------------------------------------------------
// abbsm_checker
// Port-level checks of the boot slot manager, bound to the top level.
// ----------------------------------------------------------------------------
module abbsm_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input abbsm_pkg::abbsm_rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_jump_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.jump_now |->
         rsp_payload.phase == abbsm_pkg::PH_JUMPED && rsp_payload.save_params &&
         rsp_payload.image_valid && rsp_payload.boot_slot == rsp_payload.active_slot_out)
      else $error("jump pulse without jumped phase");

   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.start_download |->
         (rsp_payload.phase == abbsm_pkg::PH_SD || rsp_payload.phase == abbsm_pkg::PH_UART) &&
         rsp_payload.download_source == (rsp_payload.phase == abbsm_pkg::PH_UART))
      else $error("download start outside an upgrade phase");

   a_download_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.download_slot != rsp_payload.active_slot_out &&
         rsp_payload.state_a_out != abbsm_pkg::ST_UNUSED &&
         rsp_payload.state_b_out != abbsm_pkg::ST_UNUSED)
      else $error("download slot or slot state out of range");

endmodule

bind ab_boot_slot_manager_top abbsm_checker u_abbsm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
